@@ sv/pcl_pkg.sv @@
// Shared constants, types and the alpha threshold table for the color lookup block.
package pcl_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SUM_W         = 32;
    localparam int DIV_W         = 40;
    localparam int QUO_W         = 20;
    localparam int QB_W          = 5;
    localparam int THR_W         = 20;
    localparam int ALPHA_LEVELS  = 256;
    localparam int ALPHA_W       = $clog2(ALPHA_LEVELS);
    localparam int COLOR_QBITS   = 8;
    localparam int ALPHA_SHIFT   = 7;

    typedef struct packed {
        logic [3:0][7:0]       color;
        logic [3:0][SUM_W-1:0] sums;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] x;
        logic [DIV_W-1:0] y;
        logic [QB_W-1:0]  qbits;
    } t_div_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_status;

    typedef logic [ALPHA_LEVELS-1:0][THR_W-1:0] t_thr_rom;

    // Long division by shift and subtract; only evaluated while building the table.
    function automatic longint unsigned f_udiv64(input longint unsigned x,
                                                 input longint unsigned y);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], x[i]};
            if (r >= y) begin
                r    = r - y;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Thresholds ceil(65280 * -ln(1 - k/256)) from the log series in 56-bit fixed point.
    function automatic t_thr_rom f_build_rom();
        t_thr_rom        rom;
        longint unsigned term;
        longint unsigned lnv;
        longint unsigned m;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned a;
        longint unsigned b;
        longint unsigned s;
        longint unsigned t;
        rom = '0;
        for (int k = 1; k < ALPHA_LEVELS; k++) begin
            term = 64'd1 << 56;
            lnv  = 0;
            m    = 1;
            term = (term * longint'(k)) >> 8;
            while (term != 0) begin
                lnv  = lnv + f_udiv64(term, m);
                m    = m + 1;
                term = (term * longint'(k)) >> 8;
            end
            hi = lnv >> 32;
            lo = lnv & 64'hFFFF_FFFF;
            a  = 64'd65280 * hi;
            b  = 64'd65280 * lo;
            s  = a + (b >> 32);
            t  = s >> 24;
            if ((s & 64'hFF_FFFF) != 0 || (b & 64'hFFFF_FFFF) != 0) begin
                t = t + 1;
            end
            rom[k] = THR_W'(t);
        end
        return rom;
    endfunction

    localparam t_thr_rom THR_ROM = f_build_rom();

endpackage

@@ sv/pcl_if.sv @@
// Valid/ready channel interfaces for the load/query input and the RGBA result.
interface pcl_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] entry_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] back_scalar;
    logic [7:0] front_scalar;

    modport source (output valid, mode, entry_index, red_in, green_in, blue_in,
                    back_scalar, front_scalar, input ready);
    modport sink   (input valid, mode, entry_index, red_in, green_in, blue_in,
                    back_scalar, front_scalar, output ready);
endinterface

interface pcl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

@@ sv/pcl_div.sv @@
// Restoring divider with saturation, one quotient bit per cycle.
module pcl_div
    import pcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_cmd    i_cmd,
    output t_div_status o_stat
);

    logic             r_busy;
    logic             r_done;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_ys;
    logic [QB_W-1:0]  r_j;
    logic [QB_W-1:0]  r_qb;
    logic [QUO_W-1:0] r_quo;
    logic             hit;

    assign hit = (r_rem >= r_ys);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if ((hit && r_j == r_qb) || r_j == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_cmd.x;
            r_ys  <= i_cmd.y << i_cmd.qbits;
            r_j   <= i_cmd.qbits;
            r_qb  <= i_cmd.qbits;
            r_quo <= '0;
        end else if (r_busy) begin
            if (hit) begin
                if (r_j == r_qb) begin
                    // saturate: quotient would not fit in the requested bits
                    r_quo <= (QUO_W'(1) << r_qb) - QUO_W'(1);
                end else begin
                    r_rem <= r_rem - r_ys;
                    r_quo <= r_quo | (QUO_W'(1) << r_j);
                end
            end
            r_ys <= r_ys >> 1;
            r_j  <= r_j - QB_W'(1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.quo  = r_quo;

endmodule

@@ sv/pcl_store.sv @@
// Table store: colors and doubled prefix sums, one write and two registered reads.
module pcl_store
    import pcl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr_a,
    input  logic [IDX_W-1:0] i_raddr_b,
    output t_entry           o_rdata_a,
    output t_entry           o_rdata_b
);

    t_entry mem [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

@@ sv/preintegrated_color_lookup_top.sv @@
// Top level of the pre-integrated color lookup: load sequencing, query sequencer, output register.
//
//  channel   dir  transaction
//  i_in      in   mode 0: load one RGB entry; mode 1: query a back/front scalar pair
//  o_out     out  one RGBA result per query, none per load
//
// A load is taken straight from idle. A query passes through the read, setup and output
// steps when both scalars name the same entry; otherwise a read step, then four passes of
// the shared divider (a setup step, then the division for a color channel or for alpha,
// waiting on the done flag), then 8 threshold probes and an output step. A pass ends
// sooner when its quotient saturates early.
// Reset clears the sequencer, the running sums and the last color; the table itself
// is not cleared. The input is not ready while a query runs, and a query waits in its
// output step while an earlier result has not been taken.
module preintegrated_color_lookup_top
    import pcl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcl_in_if.sink    i_in,
    pcl_out_if.source o_out
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SRCH  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [IDX_W-1:0]      r_lo;
    logic [IDX_W-1:0]      r_hi;
    logic [1:0]            r_ch;
    logic [3:0][7:0]       r_res;
    logic [QUO_W-1:0]      r_q;
    logic [ALPHA_W-1:0]    r_cnt;
    logic [2:0]            r_bit;
    logic [3:0][SUM_W-1:0] r_run;
    logic [3:0][7:0]       r_prev;
    logic                  r_ovalid;
    logic [3:0][7:0]       r_ores;

    logic                  accept;
    logic                  load_we;
    logic [IDX_W-1:0]      load_idx;
    logic [3:0][7:0]       load_col;
    logic [3:0][SUM_W-1:0] load_sums;
    t_entry                wdata;
    t_entry                rd_a;
    t_entry                rd_b;
    logic [IDX_W-1:0]      sb;
    logic [IDX_W-1:0]      sf;
    logic [IDX_W-1:0]      span;
    logic [SUM_W-1:0]      s_lo;
    logic [SUM_W-1:0]      s_hi;
    logic [SUM_W-1:0]      diff;
    t_div_cmd              div_cmd;
    t_div_status           div_stat;
    logic [ALPHA_W-1:0]    probe;
    logic                  out_free;

    function automatic logic [IDX_W-1:0] f_clamp(input logic [7:0] s);
        if (32'(s) >= TABLE_ENTRIES) begin
            return IDX_W'(TABLE_ENTRIES - 1);
        end
        return IDX_W'(s);
    endfunction

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // Load path: restart sums at entry zero, drop indexes beyond the table.
    assign load_idx    = IDX_W'(i_in.entry_index);
    assign load_col[0] = i_in.red_in;
    assign load_col[1] = i_in.green_in;
    assign load_col[2] = i_in.blue_in;
    assign load_col[3] = i_in.red_in + i_in.green_in + i_in.blue_in;
    assign load_we     = accept && !i_in.mode && (32'(i_in.entry_index) < TABLE_ENTRIES);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (i_in.entry_index == 8'd0) begin
                load_sums[c] = '0;
            end else begin
                load_sums[c] = r_run[c] + SUM_W'(r_prev[c]) + SUM_W'(load_col[c]);
            end
        end
    end

    assign wdata.color = load_col;
    assign wdata.sums  = load_sums;

    pcl_store u_store (
        .i_clk     (i_clk),
        .i_we      (load_we),
        .i_waddr   (load_idx),
        .i_wdata   (wdata),
        .i_raddr_a (r_lo),
        .i_raddr_b (r_hi),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign sb   = f_clamp(i_in.back_scalar);
    assign sf   = f_clamp(i_in.front_scalar);
    assign span = r_hi - r_lo;

    // Divider command for the current channel; negative differences answer zero.
    assign s_lo = rd_a.sums[r_ch];
    assign s_hi = rd_b.sums[r_ch];
    assign diff = (s_hi > s_lo) ? (s_hi - s_lo) : '0;

    always_comb begin
        div_cmd.start = (r_state == ST_SETUP) && (span != '0);
        if (r_ch == 2'd3) begin
            div_cmd.x     = DIV_W'(diff) << ALPHA_SHIFT;
            div_cmd.y     = DIV_W'(span);
            div_cmd.qbits = QB_W'(QUO_W);
        end else begin
            div_cmd.x     = DIV_W'(diff);
            div_cmd.y     = DIV_W'(span) << 1;
            div_cmd.qbits = QB_W'(COLOR_QBITS);
        end
    end

    pcl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_stat  (div_stat)
    );

    assign probe    = r_cnt | (ALPHA_W'(1) << r_bit);
    assign out_free = !r_ovalid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in.mode) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_SETUP;
            ST_SETUP: n_state = (span == '0) ? ST_OUT : ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = (r_ch == 2'd3) ? ST_SRCH : ST_SETUP;
                end
            end
            ST_SRCH: begin
                if (r_bit == 3'd0) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_run    <= '0;
            r_prev   <= '0;
        end else begin
            r_state <= n_state;
            if (load_we) begin
                r_run  <= load_sums;
                r_prev <= load_col;
            end
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_lo <= (sb < sf) ? sb : sf;
                r_hi <= (sb < sf) ? sf : sb;
                r_ch <= 2'd0;
            end
            ST_SETUP: begin
                if (span == '0) begin
                    r_res <= rd_a.color;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (r_ch == 2'd3) begin
                        r_q   <= div_stat.quo;
                        r_cnt <= '0;
                        r_bit <= 3'(ALPHA_W - 1);
                    end else begin
                        r_res[r_ch] <= div_stat.quo[7:0];
                        r_ch        <= r_ch + 2'd1;
                    end
                end
            end
            ST_SRCH: begin
                // find the highest level whose threshold the mean opacity reaches
                if (THR_ROM[probe] <= r_q) begin
                    r_cnt <= probe;
                end
                r_bit <= r_bit - 3'd1;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_ores <= r_res;
                end
            end
            default: begin
            end
        endcase
        if (r_state == ST_SRCH && r_bit == 3'd0) begin
            r_res[3] <= (THR_ROM[probe] <= r_q) ? probe : r_cnt;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.red_out   = r_ores[0];
    assign o_out.green_out = r_ores[1];
    assign o_out.blue_out  = r_ores[2];
    assign o_out.alpha_out = r_ores[3];

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the pre-integrated color lookup: directed and random load/query traffic.
module testbench;
    import pcl_pkg::*;

    typedef struct {
        bit       mode;
        bit [7:0] idx;
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] back;
        bit [7:0] front;
    } t_request;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] alpha;
    } t_rgba;

    localparam bit MODE_LOAD  = 1'b0;
    localparam bit MODE_QUERY = 1'b1;

    logic i_clk;
    logic i_rst_n;

    pcl_in_if  req_ch ();
    pcl_out_if res_ch ();

    preintegrated_color_lookup_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch.sink),
        .o_out  (res_ch.source)
    );

    t_request pending_requests[$];
    t_rgba    expected_colors[$];
    t_request in_flight;
    int       fail_count;
    int       send_gap;
    int       take_stall;
    bit       calm_phase;

    // Shadow of the table: colors (alpha = byte sum) and doubled trapezoid sums.
    bit [7:0]  shadow_color[TABLE_ENTRIES][4];
    bit [31:0] shadow_sum[TABLE_ENTRIES][4];
    bit [31:0] run_sum[4];
    bit [7:0]  last_color[4];
    longint unsigned opacity_steps[ALPHA_LEVELS];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Opacity thresholds: ceil(65280 * -ln(1 - k/256)) from the truncated log series.
    task automatic build_opacity_steps();
        longint unsigned term, lnv, m, hi, lo, a, b, s, t;
        opacity_steps[0] = 0;
        for (int k = 1; k < ALPHA_LEVELS; k++) begin
            lnv  = 0;
            m    = 1;
            term = ((64'd1 << 56) * longint'(k)) >> 8;
            while (term != 0) begin
                lnv  += term / m;
                m    += 1;
                term = (term * longint'(k)) >> 8;
            end
            hi = lnv >> 32;
            lo = lnv & 64'hFFFF_FFFF;
            a  = 64'd65280 * hi;
            b  = 64'd65280 * lo;
            s  = a + (b >> 32);
            t  = s >> 24;
            if ((s & 64'hFF_FFFF) != 0 || (b & 64'hFFFF_FFFF) != 0) t += 1;
            opacity_steps[k] = t;
        end
    endtask

    // Update the shadow table for a load, or queue the expected RGBA of a query.
    task automatic integrate_request(input t_request r);
        bit [7:0]        c[4];
        int              lo, hi, n, cnt;
        longint unsigned d, v, q;
        t_rgba           res;
        bit [7:0]        ch[4];
        if (r.mode == MODE_LOAD) begin
            c[0] = r.red;
            c[1] = r.green;
            c[2] = r.blue;
            c[3] = r.red + r.green + r.blue;
            for (int k = 0; k < 4; k++) begin
                if (r.idx == 0) run_sum[k] = 0;
                else run_sum[k] = run_sum[k] + last_color[k] + c[k];
                shadow_sum[r.idx][k]   = run_sum[k];
                shadow_color[r.idx][k] = c[k];
                last_color[k]          = c[k];
            end
            return;
        end
        lo = (r.back < r.front) ? r.back : r.front;
        hi = (r.back < r.front) ? r.front : r.back;
        n  = hi - lo;
        for (int k = 0; k < 4; k++) begin
            if (n == 0) begin
                ch[k] = shadow_color[lo][k];
            end else if (shadow_sum[hi][k] <= shadow_sum[lo][k]) begin
                // Stale or reordered loads: a falling sum reads as zero.
                ch[k] = 0;
            end else begin
                d = shadow_sum[hi][k] - shadow_sum[lo][k];
                if (k < 3) begin
                    v     = d / (2 * n);
                    ch[k] = (v > 255) ? 8'd255 : v[7:0];
                end else begin
                    q   = (d * 128) / n;
                    cnt = 0;
                    for (int j = 1; j < ALPHA_LEVELS; j++) if (opacity_steps[j] <= q) cnt++;
                    ch[k] = (cnt > 255) ? 8'd255 : cnt[7:0];
                end
            end
        end
        res.red   = ch[0];
        res.green = ch[1];
        res.blue  = ch[2];
        res.alpha = ch[3];
        expected_colors.push_back(res);
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_load(input int idx, input bit [7:0] r, input bit [7:0] g,
                              input bit [7:0] b);
        t_request t;
        t.mode  = MODE_LOAD;
        t.idx   = 8'(idx);
        t.red   = r;
        t.green = g;
        t.blue  = b;
        t.back  = 8'($urandom_range(0, 255));
        t.front = 8'($urandom_range(0, 255));
        pending_requests.push_back(t);
    endtask

    task automatic queue_query(input int back, input int front);
        t_request t;
        t.mode  = MODE_QUERY;
        t.idx   = 8'($urandom_range(0, 255));
        t.red   = 8'($urandom_range(0, 255));
        t.green = 8'($urandom_range(0, 255));
        t.blue  = 8'($urandom_range(0, 255));
        t.back  = 8'(back);
        t.front = 8'(front);
        pending_requests.push_back(t);
    endtask

    // Driver: retire the accepted transaction into the predictor, then present the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) integrate_request(in_flight);
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap     <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    in_flight           = pending_requests.pop_front();
                    req_ch.mode         <= in_flight.mode;
                    req_ch.entry_index  <= in_flight.idx;
                    req_ch.red_in       <= in_flight.red;
                    req_ch.green_in     <= in_flight.green;
                    req_ch.blue_in      <= in_flight.blue;
                    req_ch.back_scalar  <= in_flight.back;
                    req_ch.front_scalar <= in_flight.front;
                    req_ch.valid        <= 1'b1;
                    send_gap            <= pick_pause();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation, stall at random.
    always @(posedge i_clk) begin
        t_rgba e;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            take_stall   <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_colors.size() == 0) begin
                    $error("unexpected result rgba=%h_%h_%h_%h", res_ch.red_out,
                           res_ch.green_out, res_ch.blue_out, res_ch.alpha_out);
                    fail_count++;
                end else begin
                    e = expected_colors.pop_front();
                    if (res_ch.red_out !== e.red) begin
                        $error("red_out: expected %0d, actual %0d", e.red, res_ch.red_out);
                        fail_count++;
                    end
                    if (res_ch.green_out !== e.green) begin
                        $error("green_out: expected %0d, actual %0d", e.green,
                               res_ch.green_out);
                        fail_count++;
                    end
                    if (res_ch.blue_out !== e.blue) begin
                        $error("blue_out: expected %0d, actual %0d", e.blue, res_ch.blue_out);
                        fail_count++;
                    end
                    if (res_ch.alpha_out !== e.alpha) begin
                        $error("alpha_out: expected %0d, actual %0d", e.alpha,
                               res_ch.alpha_out);
                        fail_count++;
                    end
                end
            end
            if (take_stall > 0) begin
                take_stall   <= take_stall - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) take_stall <= pick_pause();
            end
        end
    end

    // Stimulus: a full directed load and queries, then random traffic.
    initial begin
        int total, r, len;
        fail_count          = 0;
        calm_phase          = 1'b0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_LOAD;
        req_ch.entry_index  = '0;
        req_ch.red_in       = '0;
        req_ch.green_in     = '0;
        req_ch.blue_in      = '0;
        req_ch.back_scalar  = '0;
        req_ch.front_scalar = '0;
        res_ch.ready        = 1'b0;
        for (int k = 0; k < 4; k++) begin
            run_sum[k]    = 0;
            last_color[k] = 0;
        end
        build_opacity_steps();

        // Load the whole table first: queries are only legal over written entries.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i == 0) queue_load(i, 8'd0, 8'd0, 8'd0);
            else if (i >= 250) queue_load(i, 8'd255, 8'd255, 8'd255);
            else queue_load(i, 8'(i), 8'(255 - i), 8'(i * 37));
        end
        queue_query(5, 5);
        queue_query(0, 0);
        queue_query(255, 255);
        queue_query(0, 255);
        queue_query(255, 0);
        queue_query(10, 11);
        queue_query(200, 17);
        queue_query(251, 255);
        queue_query(0, 1);
        // Restart the sums at entry zero, then load out of order: falling sums.
        queue_load(0, 8'd255, 8'd255, 8'd255);
        queue_load(200, 8'd1, 8'd2, 8'd3);
        queue_load(7, 8'd255, 8'd0, 8'd128);
        queue_query(150, 200);
        queue_query(200, 150);
        queue_query(0, 7);
        queue_query(7, 7);
        queue_query(0, 0);

        total = 0;
        while (total < 980) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    queue_load(i, pick_byte(), pick_byte(), pick_byte());
                total += TABLE_ENTRIES;
            end else if (r < 9) begin
                len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++)
                    queue_load(i, pick_byte(), pick_byte(), pick_byte());
                total += len;
            end else if (r < 14) begin
                queue_load($urandom_range(0, 255), pick_byte(), pick_byte(), pick_byte());
                total++;
            end else begin
                len = $urandom_range(0, 255);
                if (r < 24) queue_query(len, len);
                else if (r < 34) queue_query(len, (len + $urandom_range(1, 4)) & 8'hFF);
                else queue_query(len, $urandom_range(0, 255));
                total++;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Alternate phases with and without idling on both sides.
        while (pending_requests.size() > 0 || req_ch.valid || expected_colors.size() > 0) begin
            repeat (200) @(posedge i_clk);
            calm_phase = ($urandom_range(0, 3) == 0);
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && expected_colors.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ preintegrated_color_lookup_top.f @@
sv/pcl_pkg.sv
sv/pcl_if.sv
sv/pcl_div.sv
sv/pcl_store.sv
sv/preintegrated_color_lookup_top.sv
test/testbench.sv
